@@ hdl/cds_pkg.sv @@
package cds_pkg;

   // Field widths
   localparam int AMOUNT_BITS = 12;
   localparam int YEAR_BITS   = 14;
   localparam int MONTH_BITS  = 4;
   localparam int DAY_BITS    = 5;

   // A week count is expanded to days, so it needs three more bits
   localparam int COUNT_BITS = AMOUNT_BITS + 3;
   localparam int CMP_BITS   = (COUNT_BITS > YEAR_BITS) ? COUNT_BITS : YEAR_BITS;

   // Century split of the year, used for the leap rule
   localparam int REM_BITS  = YEAR_BITS;
   localparam int CENT_BITS = 8;
   localparam logic [REM_BITS-1:0] CENTURY  = REM_BITS'(100);
   localparam logic [REM_BITS-1:0] LAST_REM = REM_BITS'(99);

   // Calendar constants
   localparam logic [MONTH_BITS-1:0] MONTH_JAN = MONTH_BITS'(1);
   localparam logic [MONTH_BITS-1:0] MONTH_FEB = MONTH_BITS'(2);
   localparam logic [MONTH_BITS-1:0] MONTH_APR = MONTH_BITS'(4);
   localparam logic [MONTH_BITS-1:0] MONTH_JUN = MONTH_BITS'(6);
   localparam logic [MONTH_BITS-1:0] MONTH_SEP = MONTH_BITS'(9);
   localparam logic [MONTH_BITS-1:0] MONTH_NOV = MONTH_BITS'(11);
   localparam logic [MONTH_BITS-1:0] MONTH_DEC = MONTH_BITS'(12);
   localparam logic [DAY_BITS-1:0]   DAY_FIRST = DAY_BITS'(1);
   localparam logic [DAY_BITS-1:0]   DAYS_LONG = DAY_BITS'(31);
   localparam logic [DAY_BITS-1:0]   DAYS_SHORT = DAY_BITS'(30);
   localparam logic [DAY_BITS-1:0]   DAYS_FEB_LEAP = DAY_BITS'(29);
   localparam logic [DAY_BITS-1:0]   DAYS_FEB = DAY_BITS'(28);

   typedef enum logic [1:0] {
      CMD_DAYS   = 2'd0,
      CMD_WEEKS  = 2'd1,
      CMD_MONTHS = 2'd2,
      CMD_YEARS  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [YEAR_BITS-1:0]  year;
      logic [MONTH_BITS-1:0] month;
      logic [DAY_BITS-1:0]   day;
   } date_type;

   // Working date plus the year split into century count and remainder
   typedef struct packed {
      date_type             date;
      logic [REM_BITS-1:0]  rem;
      logic [CENT_BITS-1:0] cent;
   } cal_type;

   typedef struct packed {
      date_type date;
      logic     underflow;
   } result_type;

   localparam date_type DATE_FLOOR = '{year: '0, month: MONTH_JAN, day: DAY_FIRST};

   // Length of a month; codes outside 1..12 read as a long month
   function automatic logic [DAY_BITS-1:0] days_in(logic [MONTH_BITS-1:0] month, logic leap);
      logic [DAY_BITS-1:0] len;
      case (month) inside
         MONTH_FEB:                               len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
         default:                                 len = DAYS_LONG;
      endcase
      return len;
   endfunction

endpackage

@@ hdl/cds_req_if.sv @@
interface cds_req_if import cds_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             command;
   logic [AMOUNT_BITS-1:0] amount;
   logic [YEAR_BITS-1:0]   year_in;
   logic [MONTH_BITS-1:0]  month_in;
   logic [DAY_BITS-1:0]    day_in;

   modport source (output valid, command, amount, year_in, month_in, day_in, input ready);
   modport sink (input valid, command, amount, year_in, month_in, day_in, output ready);
endinterface

@@ hdl/cds_rsp_if.sv @@
interface cds_rsp_if import cds_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [YEAR_BITS-1:0]  year_out;
   logic [MONTH_BITS-1:0] month_out;
   logic [DAY_BITS-1:0]   day_out;
   logic                  underflow;

   modport source (output valid, year_out, month_out, day_out, underflow, input ready);
   modport sink (input valid, year_out, month_out, day_out, underflow, output ready);
endinterface

@@ hdl/cds_step_unit.sv @@
module cds_step_unit import cds_pkg::*; (
   input  cal_type             cur,
   input  logic                month_mode,
   output cal_type             nxt,
   output logic                underflow,
   output logic [DAY_BITS-1:0] cur_len
);

   logic                  leap;
   logic [MONTH_BITS-1:0] prev_month;
   logic [DAY_BITS-1:0]   prev_len;

   // Leap rule from the century split: on a century year test the century count
   assign leap       = (cur.rem == '0) ? (cur.cent[1:0] == 2'b00) : (cur.date.year[1:0] == 2'b00);
   assign cur_len    = days_in(cur.date.month, leap);
   assign prev_month = cur.date.month - MONTH_JAN;
   assign prev_len   = days_in(prev_month, leap);

   // Move back one day, or one month in month mode
   always_comb begin
      nxt       = cur;
      underflow = 1'b0;
      if (!month_mode && cur.date.day > DAY_FIRST) begin
         nxt.date.day = cur.date.day - DAY_FIRST;
      end else if (cur.date.month > MONTH_JAN) begin
         nxt.date.month = prev_month;
         if (!month_mode || cur.date.day > prev_len) begin
            nxt.date.day = prev_len;
         end
      end else if (cur.date.year != '0) begin
         nxt.date.year  = cur.date.year - 1'b1;
         nxt.date.month = MONTH_DEC;
         if (!month_mode) begin
            nxt.date.day = DAYS_LONG;
         end
         // keep the century split in step with the year
         if (cur.rem == '0) begin
            nxt.rem  = LAST_REM;
            nxt.cent = cur.cent - 1'b1;
         end else begin
            nxt.rem = cur.rem - 1'b1;
         end
      end else begin
         underflow = 1'b1;
      end
   end

endmodule

@@ hdl/cds_seq.sv @@
module cds_seq import cds_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  cmd_type                cmd,
   input  logic [AMOUNT_BITS-1:0] amount,
   input  date_type               date_in,
   output logic                   idle,
   output logic                   res_valid,
   input  logic                   res_take,
   output result_type             res
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CLAMP,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   cal_type               cal_ff, cal_in;
   cmd_type               cmd_ff, cmd_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  uf_ff, uf_in;

   cal_type               step_nxt;
   logic                  step_uf;
   logic [DAY_BITS-1:0]   cur_len;
   date_type              date_norm;
   logic [COUNT_BITS-1:0] week_days;

   cds_step_unit u_step (
      .cur        (cal_ff),
      .month_mode (cmd_ff == CMD_MONTHS),
      .nxt        (step_nxt),
      .underflow  (step_uf),
      .cur_len    (cur_len)
   );

   // Clamp a month of zero or above twelve, and a day of zero, onto the calendar
   always_comb begin
      date_norm = date_in;
      if (date_in.month < MONTH_JAN) begin
         date_norm.month = MONTH_JAN;
      end else if (date_in.month > MONTH_DEC) begin
         date_norm.month = MONTH_DEC;
      end
      if (date_in.day < DAY_FIRST) begin
         date_norm.day = DAY_FIRST;
      end
   end

   // Seven days a week: eight times the count less the count
   assign week_days = {amount, 3'b000} - COUNT_BITS'(amount);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cal_in   = cal_ff;
      cmd_in   = cmd_ff;
      count_in = count_ff;
      uf_in    = uf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cal_in.date = date_norm;
               cal_in.rem  = date_norm.year;
               cal_in.cent = '0;
               cmd_in      = cmd;
               uf_in       = 1'b0;
               count_in    = (cmd == CMD_WEEKS) ? week_days : COUNT_BITS'(amount);
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            // split the year by repeated subtraction of a century
            if (cal_ff.rem >= CENTURY) begin
               cal_in.rem  = cal_ff.rem - CENTURY;
               cal_in.cent = cal_ff.cent + 1'b1;
            end else begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (cal_ff.date.day > cur_len) begin
               cal_in.date.day = cur_len;
            end
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cmd_ff == CMD_YEARS) begin
               if (CMP_BITS'(count_ff) > CMP_BITS'(cal_ff.date.year)) begin
                  uf_in = 1'b1;
               end else begin
                  cal_in.date.year = cal_ff.date.year - YEAR_BITS'(count_ff);
               end
               state_in = ST_DONE;
            end else if (count_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cal_in   = step_nxt;
               count_in = count_ff - 1'b1;
               if (step_uf) begin
                  uf_in    = 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cal_ff   <= cal_in;
      cmd_ff   <= cmd_in;
      count_ff <= count_in;
      uf_ff    <= uf_in;
   end

   assign idle          = (state_ff == ST_IDLE);
   assign res_valid     = (state_ff == ST_DONE);
   assign res.date      = uf_ff ? DATE_FLOOR : cal_ff.date;
   assign res.underflow = uf_ff;

endmodule

@@ hdl/calendar_date_subtractor.sv @@
// Moves a Gregorian date back by a count of days, weeks, months or years, one item
// at a time. After an item is taken the block splits the year into centuries at one
// subtraction per cycle, fits the day to its month, and then drives the date-step unit
// once per cycle: one step per day for day and week counts or per month for month
// counts, then a check that the count has run out, and a single subtraction for
// years. The result is then handed to the output register, after which the next item
// is taken while the result waits. A result before 0000-01-01 comes back as that
// date with underflow set.
module calendar_date_subtractor import cds_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cds_req_if.sink   req_chan,
   cds_rsp_if.source rsp_chan
);

   logic       start;
   logic       seq_idle;
   logic       res_valid;
   logic       res_take;
   result_type res;
   date_type   date_in;

   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   assign date_in  = '{year: req_chan.year_in, month: req_chan.month_in, day: req_chan.day_in};
   assign req_chan.ready = seq_idle;
   assign start    = req_chan.valid && seq_idle;

   cds_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd_type'(req_chan.command)),
      .amount    (req_chan.amount),
      .date_in   (date_in),
      .idle      (seq_idle),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res)
   );

   // Load the output register when it is empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_take) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.year_out  = rsp_data_ff.date.year;
   assign rsp_chan.month_out = rsp_data_ff.date.month;
   assign rsp_chan.day_out   = rsp_data_ff.date.day;
   assign rsp_chan.underflow = rsp_data_ff.underflow;

   // Busy right after an item is taken
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_chan.ready)
      else $error("block ready in the cycle after taking an item");

   // A saturated result is the floor date
   a_floor_on_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.underflow |->
         rsp_chan.year_out == '0 && rsp_chan.month_out == MONTH_JAN &&
         rsp_chan.day_out == DAY_FIRST)
      else $error("underflow result is not the floor date");

   // Every result is a calendar month and day
   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         rsp_chan.month_out >= MONTH_JAN && rsp_chan.month_out <= MONTH_DEC &&
         rsp_chan.day_out >= DAY_FIRST && rsp_chan.day_out <= DAYS_LONG)
      else $error("result month or day out of range");

   // A result is handed over only while the sequencer is out of idle, never as an item is taken
   a_take_only_when_done: assert property (@(posedge clock) disable iff (reset)
      res_take |-> !seq_idle && !start)
      else $error("result taken outside the done state");

endmodule
